>>> hw/rtl/tcpc_pkg.sv
// tcpc_pkg: shared constants and the ones-complement add for the tcp/ipv4 checksum engine
// used by tcpc_cfg and tcp_ipv4_checksum_engine; no dependencies
`timescale 1ns / 1ps

package tcpc_pkg;

  localparam int unsigned MIN_HEADER_BYTES = 20;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0]  PROTO_WORD = 16'h0006;
  localparam logic [WORD_W-1:0]  ALL_ONES   = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 17'h1FFFF;
  localparam logic [COUNT_W-1:0] MIN_LEN    = COUNT_W'(MIN_HEADER_BYTES);

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DESTINATION_ADDRESS = 2'd1;

  // ones-complement add with end-around carry
  function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
    logic [WORD_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, t[WORD_W]};
  endfunction

endpackage

>>> hw/rtl/tcpc_cfg.sv
// tcpc_cfg: address registers and the registered fixed part of the pseudo-header sum
// depends on tcpc_pkg
`timescale 1ns / 1ps

module tcpc_cfg
  import tcpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  output logic [WORD_W-1:0]    pseudo_sum
);

  logic [ADDR_W-1:0]   src_addr_r;
  logic [ADDR_W-1:0]   dst_addr_r;
  logic [WORD_W-1:0]   pseudo_r;
  logic [WORD_W-1:0]   pseudo_nxt;
  logic [WORD_W+2:0]   total;
  logic [WORD_W:0]     fold1;

  // five words summed wide, then folded twice
  always_comb begin
    total = {3'b000, src_addr_r[31:16]} + {3'b000, src_addr_r[15:0]}
          + {3'b000, dst_addr_r[31:16]} + {3'b000, dst_addr_r[15:0]}
          + {3'b000, PROTO_WORD};
    fold1 = {1'b0, total[WORD_W-1:0]} + {{(WORD_W-2){1'b0}}, total[WORD_W+2:WORD_W]};
    pseudo_nxt = fold1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold1[WORD_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r <= '0;
      dst_addr_r <= '0;
      pseudo_r   <= PROTO_WORD;
    end else begin
      pseudo_r <= pseudo_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SOURCE_ADDRESS:      src_addr_r <= cfg_wdata;
          REG_DESTINATION_ADDRESS: dst_addr_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign pseudo_sum = pseudo_r;

endmodule

>>> hw/rtl/tcp_ipv4_checksum_engine.sv
// tcp_ipv4_checksum_engine: byte-serial tcp/ipv4 pseudo-header checksum, top level
// depends on tcpc_pkg and tcpc_cfg
//
//   channel | ports                                              | direction
//   in      | in_valid, in_ready, in_data_byte, in_last_byte     | in
//   out     | out_valid, out_ready, out_checksum_value,          | out
//           | out_checksum_ok, out_length_error                  |
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata                    | in
//
// a byte per cycle while in_ready; the running sum takes one end-around-carry add per byte pair
// a result is registered after its last byte: segment sum stage, then pseudo-header stage
// synchronous active-low reset clears the segment state, addresses and both stage valids
// a stalled output holds the stage behind it; bytes keep flowing while that stage is empty
// address writes reach the pseudo-header sum via the address register, then the sum register
`timescale 1ns / 1ps

module tcp_ipv4_checksum_engine
  import tcpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_W-1:0]    out_checksum_value,
  output logic                 out_checksum_ok,
  output logic                 out_length_error,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  logic [WORD_W-1:0]  pseudo_sum;

  logic [WORD_W-1:0]  running_sum_r, running_sum_nxt;
  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [BYTE_W-1:0]  held_byte_r, held_byte_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  logic [WORD_W-1:0]  s1_sum_r;
  logic [WORD_W-1:0]  s1_len_r;
  logic               s1_err_r;

  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_value_r;
  logic               out_ok_r;
  logic               out_err_r;

  logic               in_accept;
  logic               adv2;
  logic               odd_pos;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  sum_inc;
  logic [COUNT_W-1:0] count_inc;
  logic               len_bad;
  logic [WORD_W-1:0]  sum2;
  logic [WORD_W-1:0]  fin;

  tcpc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pseudo_sum (pseudo_sum)
  );

  // handshakes
  assign adv2      = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || adv2;
  assign in_accept = in_valid && in_ready;

  // stage 1: segment sum
  always_comb begin
    odd_pos   = byte_count_r[0];
    word      = odd_pos ? {held_byte_r, in_data_byte} : {in_data_byte, {BYTE_W{1'b0}}};
    sum_inc   = oc_add(running_sum_r, word);
    count_inc = (byte_count_r == COUNT_MAX) ? byte_count_r : byte_count_r + 1'b1;
    len_bad   = (count_inc < MIN_LEN) || count_inc[COUNT_W-1];

    running_sum_nxt = running_sum_r;
    byte_count_nxt  = byte_count_r;
    held_byte_nxt   = held_byte_r;
    if (in_accept) begin
      if (in_last_byte) begin
        running_sum_nxt = '0;
        byte_count_nxt  = '0;
        held_byte_nxt   = '0;
      end else begin
        byte_count_nxt = count_inc;
        if (odd_pos) begin
          running_sum_nxt = sum_inc;
        end else begin
          held_byte_nxt = in_data_byte;
        end
      end
    end

    if (in_accept && in_last_byte) begin
      s1_valid_nxt = 1'b1;
    end else if (adv2) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // stage 2: pseudo-header, length and complement
  always_comb begin
    sum2 = oc_add(oc_add(s1_sum_r, pseudo_sum), s1_len_r);
    fin  = ~sum2;
    if (adv2) begin
      out_valid_nxt = s1_valid_r;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r <= '0;
      byte_count_r  <= '0;
      held_byte_r   <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      running_sum_r <= running_sum_nxt;
      byte_count_r  <= byte_count_nxt;
      held_byte_r   <= held_byte_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_last_byte) begin
      s1_sum_r <= sum_inc;
      s1_len_r <= count_inc[WORD_W-1:0];
      s1_err_r <= len_bad;
    end
    if (adv2 && s1_valid_r) begin
      if (s1_err_r) begin
        out_value_r <= '0;
        out_ok_r    <= 1'b0;
        out_err_r   <= 1'b1;
      end else begin
        out_value_r <= (fin == '0) ? ALL_ONES : fin;
        out_ok_r    <= (fin == '0);
        out_err_r   <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_checksum_value = out_value_r;
  assign out_checksum_ok    = out_ok_r;
  assign out_length_error   = out_err_r;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_value_r == '0 && !out_ok_r)
    else $error("length error with nonzero checksum or ok flag");

  a_ok_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ok_r |-> out_value_r == ALL_ONES && !out_err_r)
    else $error("verified result without all-ones checksum");

  a_seg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_last_byte |=> byte_count_r == '0 && running_sum_r == '0 && s1_valid_r)
    else $error("segment state not cleared after last byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted while both stages are full and stalled");

  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv2 |=> out_valid_r)
    else $error("stage 1 result lost on its way to the output register");

endmodule

>>> sim/tb_tcp_ipv4_checksum_engine.sv
// tb_tcp_ipv4_checksum_engine: self-checking testbench for the tcp/ipv4 checksum engine
// streams segments byte by byte under random handshake gaps and compares every result
// against an in-bench model of the pseudo-header sum; depends on tcpc_pkg and the rtl
`timescale 1ns / 1ps

module tb_tcp_ipv4_checksum_engine
  import tcpc_pkg::*;
();

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 2;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CFG_SETTLE     = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 160;
  localparam int RANDOM_RESULTS = 4;
  localparam int MAX_REPORTS    = 10;
  localparam int FILL_RANDOM    = -1;
  localparam int CSUM_HI_POS    = 16;
  localparam int CSUM_LO_POS    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [COUNT_W-1:0]   MAX_SEG_LEN = 17'h0FFFF;

  typedef struct packed {
    logic [WORD_W-1:0] csum;
    logic              verified;
    logic              len_error;
  } csum_result_t;

  typedef logic [BYTE_W-1:0] byte_queue_t[$];

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_data_byte;
  logic                 in_last_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [WORD_W-1:0]    out_checksum_value;
  logic                 out_checksum_ok;
  logic                 out_length_error;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_wdata;

  // model state
  logic [WORD_W-1:0]  seg_sum   = '0;
  logic [COUNT_W-1:0] seg_count = '0;
  logic [BYTE_W-1:0]  seg_hi    = '0;
  logic [ADDR_W-1:0]  src_addr  = '0;
  logic [ADDR_W-1:0]  dst_addr  = '0;

  csum_result_t pending_checksums[$];
  int           checksums_predicted = 0;
  int           mismatch_count      = 0;
  int           idle_cycles         = 0;
  int           hold_cycles         = 0;
  bit           tx_no_idle          = 1'b0;
  bit           rx_no_idle          = 1'b0;

  tcp_ipv4_checksum_engine dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_checksum_value (out_checksum_value),
    .out_checksum_ok    (out_checksum_ok),
    .out_length_error   (out_length_error),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [31:0] t;
    t = {16'h0, a} + {16'h0, b};
    t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
    return t[15:0];
  endfunction

  // folds one byte into the segment; returns 1 when the byte closes the segment
  function automatic bit fold_segment_byte(input logic [BYTE_W-1:0] data, input logic last,
                                           output csum_result_t res);
    logic               odd_pos;
    logic [WORD_W-1:0]  s;
    logic [WORD_W-1:0]  fin;
    logic [COUNT_W-1:0] len;
    res = '0;
    odd_pos = seg_count[0];
    if (odd_pos) begin
      seg_sum = ones_add(seg_sum, {seg_hi, data});
    end else begin
      seg_hi = data;
    end
    if (seg_count != COUNT_MAX) begin
      seg_count = seg_count + 17'd1;
    end
    if (!last) begin
      return 1'b0;
    end
    len = seg_count;
    if (len < MIN_LEN || len > MAX_SEG_LEN) begin
      res.csum      = '0;
      res.verified  = 1'b0;
      res.len_error = 1'b1;
    end else begin
      s = seg_sum;
      if (!odd_pos) begin
        s = ones_add(s, {data, 8'h00});
      end
      s = ones_add(s, src_addr[31:16]);
      s = ones_add(s, src_addr[15:0]);
      s = ones_add(s, dst_addr[31:16]);
      s = ones_add(s, dst_addr[15:0]);
      s = ones_add(s, PROTO_WORD);
      s = ones_add(s, len[15:0]);
      fin = ~s;
      res.csum      = (fin == '0) ? ALL_ONES : fin;
      res.verified  = (fin == '0);
      res.len_error = 1'b0;
    end
    seg_sum   = '0;
    seg_count = '0;
    seg_hi    = '0;
    return 1'b1;
  endfunction

  // result of a whole segment, leaving the model state untouched
  function automatic csum_result_t checksum_of(input byte_queue_t seg);
    logic [WORD_W-1:0]  keep_sum;
    logic [COUNT_W-1:0] keep_count;
    logic [BYTE_W-1:0]  keep_hi;
    csum_result_t       res;
    keep_sum   = seg_sum;
    keep_count = seg_count;
    keep_hi    = seg_hi;
    seg_sum    = '0;
    seg_count  = '0;
    seg_hi     = '0;
    res        = '0;
    foreach (seg[i]) begin
      void'(fold_segment_byte(seg[i], i == seg.size() - 1, res));
    end
    seg_sum   = keep_sum;
    seg_count = keep_count;
    seg_hi    = keep_hi;
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return ADDR_W'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic send_segment_byte(input logic [BYTE_W-1:0] data, input logic last);
    int           gap;
    csum_result_t res;
    gap = tx_no_idle ? 0 : int'($urandom_range(0, 13));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (fold_segment_byte(data, last, res)) begin
      pending_checksums.push_back(res);
      checksums_predicted++;
    end
  endtask

  // fill_byte below zero gives random content; with_csum plants a checksum at bytes 16-17 if len > 17
  task automatic send_segment(input int len, input int fill_byte, input bit with_csum);
    byte_queue_t  seg;
    csum_result_t res;
    for (int i = 0; i < len; i++) begin
      seg.push_back((fill_byte < 0) ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(fill_byte));
    end
    if (with_csum && len > CSUM_LO_POS) begin
      seg[CSUM_HI_POS] = '0;
      seg[CSUM_LO_POS] = '0;
      res = checksum_of(seg);
      seg[CSUM_HI_POS] = res.csum[15:8];
      seg[CSUM_LO_POS] = res.csum[7:0];
    end
    foreach (seg[i]) begin
      send_segment_byte(seg[i], i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_checksums.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    wait_drained();
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_SOURCE_ADDRESS) begin
      src_addr = data;
    end else if (idx == REG_DESTINATION_ADDRESS) begin
      dst_addr = data;
    end
    repeat (2) @(posedge clk);
  endtask

  task automatic load_addresses(input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst);
    write_reg(REG_SOURCE_ADDRESS, src);
    write_reg(REG_DESTINATION_ADDRESS, dst);
  endtask

  task automatic test_short_segments();
    send_segment(1, 8'hFF, 1'b0);
    send_segment(2, 8'h00, 1'b0);
    send_segment(19, 8'hFF, 1'b0);
    wait_drained();
  endtask

  task automatic test_boundary_lengths();
    send_segment(20, 8'hFF, 1'b0);
    send_segment(20, 8'h00, 1'b0);
    send_segment(21, FILL_RANDOM, 1'b0);
    send_segment(22, FILL_RANDOM, 1'b0);
    wait_drained();
  endtask

  task automatic test_verifying_segments();
    send_segment(20, FILL_RANDOM, 1'b1);
    send_segment(33, FILL_RANDOM, 1'b1);
    send_segment(20, 8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_address_settings();
    load_addresses('1, '1);
    send_segment(20, 8'hFF, 1'b0);
    send_segment(25, FILL_RANDOM, 1'b1);
    load_addresses('1, '0);
    send_segment(24, FILL_RANDOM, 1'b0);
    load_addresses(ADDR_W'($urandom), ADDR_W'($urandom));
    send_segment(31, FILL_RANDOM, 1'b1);
    // spare indexes must leave both addresses alone
    write_reg(REG_SPARE_A, ADDR_W'($urandom));
    write_reg(REG_SPARE_B, '1);
    send_segment(20, FILL_RANDOM, 1'b0);
    load_addresses('0, '0);
    send_segment(23, FILL_RANDOM, 1'b0);
    wait_drained();
  endtask

  task automatic test_paced_segments();
    for (int i = 0; i < 6; i++) begin
      send_segment(int'($urandom_range(20, 30)), FILL_RANDOM, i[0]);
      wait_drained();
    end
  endtask

  task automatic test_output_stall();
    tx_no_idle  = 1'b1;
    hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) begin
      send_segment(int'($urandom_range(1, 3)), FILL_RANDOM, 1'b0);
    end
    send_segment(20, FILL_RANDOM, 1'b1);
    send_segment(21, FILL_RANDOM, 1'b0);
    tx_no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int items;
    int first_result;
    int len;
    int kind;
    items        = 0;
    first_result = checksums_predicted;
    while (items < RANDOM_ITEMS || checksums_predicted - first_result < RANDOM_RESULTS) begin
      if ($urandom_range(0, 19) == 0) begin
        load_addresses(pick_address(), pick_address());
      end
      if ($urandom_range(0, 29) == 0) begin
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, ADDR_W'($urandom));
      end
      tx_no_idle = ($urandom_range(0, 4) == 0);
      rx_no_idle = ($urandom_range(0, 4) == 0);
      kind = int'($urandom_range(0, 9));
      len  = (kind == 0) ? int'($urandom_range(1, 19)) : int'($urandom_range(20, 40));
      send_segment(len, FILL_RANDOM, kind >= 6);
      items += len;
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    wait_drained();
  endtask

  // result side: random stalls per transaction, plus one long hold on request
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = rx_no_idle ? 0 : int'($urandom_range(0, 13));
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
    end
  end

  always @(posedge clk) begin
    csum_result_t got;
    csum_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      got = {out_checksum_value, out_checksum_ok, out_length_error};
      if (pending_checksums.size() == 0) begin
        note_mismatch($sformatf("unexpected transaction: checksum %h ok %b length_error %b",
                                got.csum, got.verified, got.len_error));
      end else begin
        want = pending_checksums.pop_front();
        if (got.csum !== want.csum) begin
          note_mismatch($sformatf("checksum_value: expected %h, got %h", want.csum, got.csum));
        end
        if (got.verified !== want.verified) begin
          note_mismatch($sformatf("checksum_ok: expected %b, got %b",
                                  want.verified, got.verified));
        end
        if (got.len_error !== want.len_error) begin
          note_mismatch($sformatf("length_error: expected %b, got %b",
                                  want.len_error, got.len_error));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid === 1'b1 && in_ready === 1'b1) ||
        (out_valid === 1'b1 && out_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    in_last_byte <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= REG_SOURCE_ADDRESS;
    cfg_wdata    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_segments();
    test_boundary_lengths();
    test_verifying_segments();
    test_address_settings();
    test_paced_segments();
    test_output_stall();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_checksums.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_checksums.size()));
    end
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
